// ===== rtl/tpdg_pkg.sv =====
// Shared types, constants and helpers for the transfer pause deadline gate.
`default_nettype none

package tpdg_pkg;

    localparam int COUNTER_WIDTH = 32;
    localparam int ACTIVE_WIDTH  = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int S_TDATA_W  = 184;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 296;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int NUM_CNT  = 5;
    localparam int CNT_OK   = 0;
    localparam int CNT_ABRT = 1;
    localparam int CNT_SLOW = 2;
    localparam int CNT_CONN = 3;
    localparam int CNT_PUB  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHELL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW   = 2'd3;

    localparam logic [15:0] PAUSE_MS_RST  = 16'd2000;
    localparam logic [15:0] SHELL_MS_RST  = 16'd15000;
    localparam logic [16:0] WINDOW_MS_RST = 17'd45000;
    localparam logic [31:0] SLOW_MS_RST   = 32'd1000;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_BEGIN  = 3'd1,
        CMD_END    = 3'd2,
        CMD_SHELL  = 3'd3,
        CMD_CONN   = 3'd4,
        CMD_PUB    = 3'd5,
        CMD_STREAM = 3'd6,
        CMD_QUERY  = 3'd7
    } t_cmd;

    // Classified word passed from front to back.
    typedef struct packed {
        t_cmd               cmd;
        logic [31:0]        now;
        logic [31:0]        pause_dl;
        logic [15:0]        pause_left;
        logic [31:0]        cand_dl;
        logic [16:0]        cand_left;
        logic               stream_ok;
        logic               slow;
        logic [3:0]         reason;
        logic signed [15:0] err;
        logic [31:0]        sent;
        logic [31:0]        total;
    } t_item;

    // Remaining time to a wrap-safe deadline; zero deadline means none.
    function automatic logic [31:0] time_left(input logic [31:0] now,
                                              input logic [31:0] due);
        logic [31:0] diff;
        diff = now - due;
        if (due == 32'd0 || !diff[31]) begin
            return 32'd0;
        end
        return due - now;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tpdg_front.sv =====
// Front end: configuration registers and per-word classification.
`default_nettype none

module tpdg_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [tpdg_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [tpdg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic [tpdg_pkg::S_TDATA_W-1:0]   i_tdata,
    input  wire logic [tpdg_pkg::S_TUSER_W-1:0]   i_tuser,
    output tpdg_pkg::t_item                       o_item
);

    logic [15:0] r_pause_ms;
    logic [15:0] r_shell_ms;
    logic [16:0] r_window_ms;
    logic [31:0] r_slow_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pause_ms  <= tpdg_pkg::PAUSE_MS_RST;
            r_shell_ms  <= tpdg_pkg::SHELL_MS_RST;
            r_window_ms <= tpdg_pkg::WINDOW_MS_RST;
            r_slow_ms   <= tpdg_pkg::SLOW_MS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tpdg_pkg::CFG_PAUSE:  r_pause_ms  <= i_cfg_data[15:0];
                tpdg_pkg::CFG_SHELL:  r_shell_ms  <= i_cfg_data[15:0];
                tpdg_pkg::CFG_WINDOW: r_window_ms <= i_cfg_data[16:0];
                tpdg_pkg::CFG_SLOW:   r_slow_ms   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    logic [31:0] now;
    logic [31:0] elapsed;
    logic [31:0] worst;
    logic [31:0] shell_dl;
    logic [16:0] shell_left;
    logic [16:0] alt_off;
    logic [31:0] alt_dl;
    logic [16:0] alt_left;
    logic        in_window;
    logic        use_alt;

    assign now     = i_tdata[31:0];
    assign elapsed = i_tdata[63:32];
    assign worst   = i_tdata[100:69];

    // now + d with 0 < d < 2^31 leaves d, unless the sum lands on zero
    assign shell_dl   = now + 32'(r_shell_ms);
    assign shell_left = (shell_dl == 32'd0) ? 17'd0 : {1'b0, r_shell_ms};

    assign in_window = (elapsed != 32'd0) && (elapsed < 32'(r_window_ms));
    assign alt_off   = r_window_ms - elapsed[16:0];
    assign alt_dl    = now + 32'(alt_off);
    assign alt_left  = (alt_dl == 32'd0) ? 17'd0 : alt_off;
    assign use_alt   = in_window && (alt_left > shell_left);

    always_comb begin
        o_item.cmd        = tpdg_pkg::t_cmd'(i_tuser);
        o_item.now        = now;
        o_item.pause_dl   = now + 32'(r_pause_ms);
        o_item.pause_left = (o_item.pause_dl == 32'd0) ? 16'd0 : r_pause_ms;
        o_item.cand_dl    = use_alt ? alt_dl : shell_dl;
        o_item.cand_left  = use_alt ? alt_left : shell_left;
        o_item.stream_ok  = i_tdata[64];
        o_item.slow       = (worst >= r_slow_ms);
        o_item.reason     = i_tdata[68:65];
        o_item.err        = i_tdata[116:101];
        o_item.sent       = i_tdata[148:117];
        o_item.total      = i_tdata[180:149];
    end

endmodule

`default_nettype wire

// ===== rtl/tpdg_queue.sv =====
// Short FIFO of classified words between front and back.
`default_nettype none

module tpdg_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire tpdg_pkg::t_item i_item,
    output logic           o_ready,
    input  wire logic      i_pop,
    output logic           o_valid,
    output tpdg_pkg::t_item o_item
);

    tpdg_pkg::t_item                 r_mem [tpdg_pkg::QUEUE_DEPTH];
    logic [tpdg_pkg::QUEUE_AW-1:0]   r_wr_ptr;
    logic [tpdg_pkg::QUEUE_AW-1:0]   r_rd_ptr;
    logic [tpdg_pkg::QUEUE_AW:0]     r_count;
    logic [tpdg_pkg::QUEUE_AW:0]     n_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_ready = (r_count != (tpdg_pkg::QUEUE_AW+1)'(tpdg_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + (tpdg_pkg::QUEUE_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (tpdg_pkg::QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + tpdg_pkg::QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + tpdg_pkg::QUEUE_AW'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tpdg_back.sv =====
// Back end: applies events to transfer state and registers result words.
`default_nettype none

module tpdg_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire tpdg_pkg::t_item                 i_item,
    output logic                                 o_pop,
    output logic                                 o_tvalid,
    input  wire logic                            i_tready,
    output logic [tpdg_pkg::M_TDATA_W-1:0]       o_tdata
);

    localparam int CW = tpdg_pkg::COUNTER_WIDTH;
    localparam int AW = tpdg_pkg::ACTIVE_WIDTH;

    logic [AW-1:0]        r_active;
    logic [31:0]          r_pause_dl;
    logic [31:0]          r_prio_dl;
    logic [CW-1:0]        r_cnt [tpdg_pkg::NUM_CNT];
    logic [3:0]           r_reason;
    logic signed [15:0]   r_err;
    logic [31:0]          r_sent;
    logic [31:0]          r_total;
    logic                 r_out_valid;
    logic [tpdg_pkg::M_TDATA_W-1:0] r_out_data;

    logic [AW-1:0]        n_active;
    logic [31:0]          n_pause_dl;
    logic [31:0]          n_prio_dl;
    logic [CW-1:0]        n_cnt [tpdg_pkg::NUM_CNT];
    logic [3:0]           n_reason;
    logic signed [15:0]   n_err;
    logic [31:0]          n_sent;
    logic [31:0]          n_total;
    logic [31:0]          n_pause_left;
    logic [31:0]          n_prio_left;
    logic [31:0]          stored_pause_left;
    logic [31:0]          stored_prio_left;
    logic [31:0]          max_left;
    logic                 pause_now;
    logic [tpdg_pkg::M_TDATA_W-1:0] n_out_data;
    logic                 load;

    assign load     = i_valid && (!r_out_valid || i_tready);
    assign o_pop    = load;
    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;

    assign stored_pause_left = tpdg_pkg::time_left(i_item.now, r_pause_dl);
    assign stored_prio_left  = tpdg_pkg::time_left(i_item.now, r_prio_dl);

    always_comb begin
        n_active     = r_active;
        n_pause_dl   = r_pause_dl;
        n_prio_dl    = r_prio_dl;
        n_cnt        = r_cnt;
        n_reason     = r_reason;
        n_err        = r_err;
        n_sent       = r_sent;
        n_total      = r_total;
        n_pause_left = stored_pause_left;
        n_prio_left  = stored_prio_left;
        case (i_item.cmd)
            tpdg_pkg::CMD_CLEAR: begin
                n_active     = '0;
                n_pause_dl   = '0;
                n_prio_dl    = '0;
                for (int i = 0; i < tpdg_pkg::NUM_CNT; i++) begin
                    n_cnt[i] = '0;
                end
                n_reason     = '0;
                n_err        = '0;
                n_sent       = '0;
                n_total      = '0;
                n_pause_left = '0;
                n_prio_left  = '0;
            end
            tpdg_pkg::CMD_BEGIN: begin
                if (r_active != '1) begin
                    n_active = r_active + AW'(1);
                end
                n_pause_dl   = i_item.pause_dl;
                n_pause_left = 32'(i_item.pause_left);
            end
            tpdg_pkg::CMD_END: begin
                if (r_active != '0) begin
                    n_active = r_active - AW'(1);
                end
                n_pause_dl   = i_item.pause_dl;
                n_pause_left = 32'(i_item.pause_left);
            end
            tpdg_pkg::CMD_SHELL: begin
                if (32'(i_item.cand_left) > stored_prio_left) begin
                    n_prio_dl   = i_item.cand_dl;
                    n_prio_left = 32'(i_item.cand_left);
                end
            end
            tpdg_pkg::CMD_CONN: begin
                n_cnt[tpdg_pkg::CNT_CONN] = r_cnt[tpdg_pkg::CNT_CONN] + CW'(1);
            end
            tpdg_pkg::CMD_PUB: begin
                n_cnt[tpdg_pkg::CNT_PUB] = r_cnt[tpdg_pkg::CNT_PUB] + CW'(1);
            end
            tpdg_pkg::CMD_STREAM: begin
                if (i_item.stream_ok) begin
                    n_cnt[tpdg_pkg::CNT_OK] = r_cnt[tpdg_pkg::CNT_OK] + CW'(1);
                end else begin
                    n_cnt[tpdg_pkg::CNT_ABRT] = r_cnt[tpdg_pkg::CNT_ABRT] + CW'(1);
                end
                if (i_item.slow) begin
                    n_cnt[tpdg_pkg::CNT_SLOW] = r_cnt[tpdg_pkg::CNT_SLOW] + CW'(1);
                end
                n_reason = i_item.reason;
                n_err    = i_item.err;
                n_sent   = i_item.sent;
                n_total  = i_item.total;
            end
            default: ;
        endcase
    end

    assign max_left  = (n_pause_left > n_prio_left) ? n_pause_left : n_prio_left;
    assign pause_now = (n_active != '0) || (n_pause_left != '0) || (n_prio_left != '0);

    assign n_out_data = {
        3'd0,
        n_total,
        n_sent,
        n_err,
        n_reason,
        32'(n_cnt[tpdg_pkg::CNT_PUB]),
        32'(n_cnt[tpdg_pkg::CNT_CONN]),
        32'(n_cnt[tpdg_pkg::CNT_SLOW]),
        32'(n_cnt[tpdg_pkg::CNT_ABRT]),
        32'(n_cnt[tpdg_pkg::CNT_OK]),
        16'(n_active),
        max_left,
        pause_now
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_pause_dl  <= '0;
            r_prio_dl   <= '0;
            for (int i = 0; i < tpdg_pkg::NUM_CNT; i++) begin
                r_cnt[i] <= '0;
            end
            r_reason    <= '0;
            r_err       <= '0;
            r_sent      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_active    <= n_active;
            r_pause_dl  <= n_pause_dl;
            r_prio_dl   <= n_prio_dl;
            r_cnt       <= n_cnt;
            r_reason    <= n_reason;
            r_err       <= n_err;
            r_sent      <= n_sent;
            r_total     <= n_total;
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/transfer_pause_deadline_gate_top.sv =====
// Top level of the transfer pause deadline gate.
// Path: an accepted word is queued, then loaded into the output register when it is free.
// Throughput: one word per cycle while m_axis is ready; a 4-word queue buffers stalls.
// Reset (synchronous, i_rst_n low): counters, deadlines and last-result fields clear,
// configuration returns to 2000/15000/45000/1000 ms, queue and output empty.
`default_nettype none

module transfer_pause_deadline_gate_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [tpdg_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [tpdg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // now_time, connect_elapsed, stream_ok, stop_reason, worst_write_time,
    // socket_error, bytes_sent, bytes_total, zero pad
    input  wire logic [tpdg_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // command
    input  wire logic [tpdg_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // pause_now, pause_left, active_now, ok_total, abort_total, slow_total,
    // connect_defer_total, publish_defer_total, recent_reason, recent_error,
    // recent_sent, recent_total, zero pad
    output logic [tpdg_pkg::M_TDATA_W-1:0]        m_axis_tdata
);

    tpdg_pkg::t_item front_item;
    tpdg_pkg::t_item back_item;
    logic            q_valid;
    logic            q_pop;

    tpdg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tdata    (s_axis_tdata),
        .i_tuser    (s_axis_tuser),
        .o_item     (front_item)
    );

    tpdg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_item  (front_item),
        .o_ready (s_axis_tready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (back_item)
    );

    tpdg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (back_item),
        .o_pop    (q_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/tpdg_checker.sv =====
// Port-level checks for the transfer pause deadline gate, bound to the top level.
`default_nettype none

module tpdg_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [tpdg_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_left_pause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[32:1] != 32'd0) |-> m_axis_tdata[0])
        else $error("time left without pause flag");

    a_active_pause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[48:33] != 16'd0) |-> m_axis_tdata[0])
        else $error("active transfers without pause flag");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output empty");

endmodule

bind transfer_pause_deadline_gate_top tpdg_checker u_tpdg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for transfer_pause_deadline_gate_top: random and directed event words.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpdg_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_WORDS  = 200;
    localparam int RAND_PHASES  = 7;
    localparam int FILL_BEGINS  = 24;

    // event word, lowest field last
    typedef struct packed {
        logic [2:0]         pad;
        logic [31:0]        bytes_total;
        logic [31:0]        bytes_sent;
        logic signed [15:0] sock_err;
        logic [31:0]        worst_ms;
        logic [3:0]         reason;
        logic               ok;
        logic [31:0]        elapsed;
        logic [31:0]        now;
    } t_event_word;

    // status word, lowest field last
    typedef struct packed {
        logic [2:0]         pad;
        logic [31:0]        total_recent;
        logic [31:0]        sent_recent;
        logic signed [15:0] last_err;
        logic [3:0]         last_reason;
        logic [31:0]        pub_defer;
        logic [31:0]        conn_defer;
        logic [31:0]        slow_cnt;
        logic [31:0]        abort_cnt;
        logic [31:0]        ok_cnt;
        logic [15:0]        active;
        logic [31:0]        left_ms;
        logic               pause;
    } t_status_word;

    class pause_gate_model;
        logic [15:0] pause_ms;
        logic [15:0] shell_ms;
        logic [16:0] window_ms;
        logic [31:0] slow_ms;

        logic [15:0] act_level;
        logic [31:0] pause_due;
        logic [31:0] prio_due;
        logic [31:0] stream_cnt[5];
        logic [3:0]  last_reason;
        logic [15:0] last_err;
        logic [31:0] sent_recent;
        logic [31:0] total_recent;

        t_status_word expected_reports[$];
        int error_count;

        function new();
            pause_ms    = PAUSE_MS_RST;
            shell_ms    = SHELL_MS_RST;
            window_ms   = WINDOW_MS_RST;
            slow_ms     = SLOW_MS_RST;
            error_count = 0;
            clear_all();
        endfunction

        function void clear_all();
            act_level    = '0;
            pause_due    = '0;
            prio_due     = '0;
            foreach (stream_cnt[k]) stream_cnt[k] = '0;
            last_reason  = '0;
            last_err     = '0;
            sent_recent  = '0;
            total_recent = '0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_PAUSE:  pause_ms  = data[15:0];
                CFG_SHELL:  shell_ms  = data[15:0];
                CFG_WINDOW: window_ms = data[16:0];
                CFG_SLOW:   slow_ms   = data;
                default: ;
            endcase
        endfunction

        function logic [31:0] ms_remaining(logic [31:0] now, logic [31:0] due);
            logic [31:0] diff;
            diff = now - due;
            if (due == '0 || !diff[31]) return '0;
            return due - now;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void take_event(t_cmd cmd, t_event_word w);
            logic [31:0] cand;
            logic [31:0] alt;
            logic [31:0] lp;
            logic [31:0] lq;
            t_status_word r;
            case (cmd)
                CMD_CLEAR: clear_all();
                CMD_BEGIN: begin
                    if (act_level != '1) act_level++;
                    pause_due = w.now + {16'd0, pause_ms};
                end
                CMD_END: begin
                    if (act_level != '0) act_level--;
                    pause_due = w.now + {16'd0, pause_ms};
                end
                CMD_SHELL: begin
                    cand = w.now + {16'd0, shell_ms};
                    if (w.elapsed != '0 && w.elapsed < {15'd0, window_ms}) begin
                        alt = w.now + ({15'd0, window_ms} - w.elapsed);
                        if (ms_remaining(w.now, alt) > ms_remaining(w.now, cand)) cand = alt;
                    end
                    if (ms_remaining(w.now, cand) > ms_remaining(w.now, prio_due))
                        prio_due = cand;
                end
                CMD_CONN: stream_cnt[CNT_CONN]++;
                CMD_PUB:  stream_cnt[CNT_PUB]++;
                CMD_STREAM: begin
                    if (w.ok) stream_cnt[CNT_OK]++;
                    else stream_cnt[CNT_ABRT]++;
                    if (w.worst_ms >= slow_ms) stream_cnt[CNT_SLOW]++;
                    last_reason  = w.reason;
                    last_err     = w.sock_err;
                    sent_recent  = w.bytes_sent;
                    total_recent = w.bytes_total;
                end
                default: ;
            endcase
            lp = ms_remaining(w.now, pause_due);
            lq = ms_remaining(w.now, prio_due);
            r              = '0;
            r.pause        = (act_level != '0) || (lp != '0) || (lq != '0);
            r.left_ms      = (lp > lq) ? lp : lq;
            r.active       = act_level;
            r.ok_cnt       = stream_cnt[CNT_OK];
            r.abort_cnt    = stream_cnt[CNT_ABRT];
            r.slow_cnt     = stream_cnt[CNT_SLOW];
            r.conn_defer   = stream_cnt[CNT_CONN];
            r.pub_defer    = stream_cnt[CNT_PUB];
            r.last_reason  = last_reason;
            r.last_err     = last_err;
            r.sent_recent  = sent_recent;
            r.total_recent = total_recent;
            expected_reports.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (exp_v !== got_v) begin
                error_count++;
                if (error_count <= 40)
                    $display("%0t: %s expected %h actual %h", $time, name, exp_v, got_v);
            end
        endfunction

        function void check_report(t_status_word got);
            t_status_word e;
            if (expected_reports.size() == 0) begin
                error_count++;
                if (error_count <= 40)
                    $display("%0t: word with none expected, expected none actual %h",
                             $time, got);
                return;
            end
            e = expected_reports.pop_front();
            check_field("pause_now",           32'(e.pause),       32'(got.pause));
            check_field("pause_left",          e.left_ms,          got.left_ms);
            check_field("active_now",          32'(e.active),      32'(got.active));
            check_field("ok_total",            e.ok_cnt,           got.ok_cnt);
            check_field("abort_total",         e.abort_cnt,        got.abort_cnt);
            check_field("slow_total",          e.slow_cnt,         got.slow_cnt);
            check_field("connect_defer_total", e.conn_defer,       got.conn_defer);
            check_field("publish_defer_total", e.pub_defer,        got.pub_defer);
            check_field("recent_reason",       32'(e.last_reason), 32'(got.last_reason));
            check_field("recent_error",        32'(e.last_err),    32'(got.last_err));
            check_field("recent_sent",         e.sent_recent,      got.sent_recent);
            check_field("recent_total",        e.total_recent,     got.total_recent);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    pause_gate_model gate;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;
    logic [31:0] ms_now;

    transfer_pause_deadline_gate_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            gate.check_report(t_status_word'(m_axis_tdata));
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL transfer_pause_deadline_gate_top");
            $finish;
        end
    end

    task automatic send_word(t_cmd c, t_event_word w);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= c;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        gate.take_event(c, w);
    endtask

    task automatic send_at(t_cmd c, logic [31:0] now, logic [31:0] elapsed);
        t_event_word w;
        w         = '0;
        w.now     = now;
        w.elapsed = elapsed;
        send_word(c, w);
    endtask

    task automatic send_stream(logic ok, logic [3:0] reason, logic [31:0] worst,
                               logic [15:0] err, logic [31:0] sent, logic [31:0] total);
        t_event_word w;
        w             = '0;
        w.now         = 32'd5000;
        w.ok          = ok;
        w.reason      = reason;
        w.worst_ms    = worst;
        w.sock_err    = err;
        w.bytes_sent  = sent;
        w.bytes_total = total;
        send_word(CMD_STREAM, w);
    endtask

    // stop sending until every status word is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (gate.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_config(logic [31:0] p, logic [31:0] s, logic [31:0] win,
                                logic [31:0] thr);
        logic [31:0] vals[4];
        vals = '{p, s, win, thr};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            gate.set_register(CFG_IDX_W'(k), vals[k]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_word(output t_cmd c, output t_event_word w);
        int r;
        logic [31:0] win;
        win = {15'd0, gate.window_ms};
        r = $urandom_range(0, 99);
        if (r < 3) ms_now = $urandom;
        else if (r < 6) ms_now = 32'd0 - {16'd0, gate.pause_ms};
        else if (r < 9) ms_now = 32'd0 - {16'd0, gate.shell_ms};
        else ms_now = ms_now + $urandom_range(0, 2500);

        w             = '0;
        w.now         = ms_now;
        w.ok          = 1'($urandom_range(0, 1));
        w.reason      = 4'($urandom);
        w.sock_err    = 16'($urandom);
        w.bytes_sent  = $urandom;
        w.bytes_total = $urandom;
        case ($urandom_range(0, 9))
            0, 1:    w.elapsed = '0;
            2:       w.elapsed = 32'd1;
            3:       w.elapsed = win;
            4:       w.elapsed = win - 32'd1;
            5:       w.elapsed = $urandom;
            default: w.elapsed = $urandom_range(0, win + 2000);
        endcase
        case ($urandom_range(0, 7))
            0:       w.worst_ms = gate.slow_ms;
            1:       w.worst_ms = gate.slow_ms - 32'd1;
            2:       w.worst_ms = gate.slow_ms + 32'd1;
            3:       w.worst_ms = $urandom;
            default: w.worst_ms = $urandom_range(0, 3000);
        endcase

        r = $urandom_range(0, 99);
        if (r < 20)      c = CMD_BEGIN;
        else if (r < 38) c = CMD_END;
        else if (r < 52) c = CMD_SHELL;
        else if (r < 60) c = CMD_CONN;
        else if (r < 66) c = CMD_PUB;
        else if (r < 82) c = CMD_STREAM;
        else if (r < 97) c = CMD_QUERY;
        else             c = CMD_CLEAR;
    endtask

    initial begin
        t_event_word w;
        t_cmd        c;
        gate = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words at reset settings
        send_at(CMD_QUERY, 32'd0, 32'd0);
        send_at(CMD_END, 32'd100, 32'd0);
        send_at(CMD_QUERY, 32'd2100, 32'd0);
        send_at(CMD_QUERY, 32'd2099, 32'd0);
        send_at(CMD_BEGIN, 32'hFFFF_F830, 32'd0);
        send_at(CMD_END, 32'hFFFF_F830, 32'd0);
        send_at(CMD_SHELL, 32'd1000, 32'd0);
        send_at(CMD_SHELL, 32'd1000, 32'd1);
        send_at(CMD_SHELL, 32'd1000, 32'd45000);
        send_at(CMD_SHELL, 32'd1000, 32'd44999);
        send_at(CMD_SHELL, 32'd1000, 32'hFFFF_FFFF);
        send_at(CMD_QUERY, 32'd45999 - 32'h8000_0000, 32'd0);
        send_at(CMD_QUERY, 32'd45999 - 32'h7FFF_FFFF, 32'd0);
        send_stream(1'b1, 4'hF, 32'd999, 16'h8000, 32'hFFFF_FFFF, 32'd0);
        send_stream(1'b0, 4'h0, 32'd1000, 16'h7FFF, 32'd0, 32'hFFFF_FFFF);
        send_stream(1'b0, 4'h5, 32'hFFFF_FFFF, 16'hFFFF, 32'h1234_5678, 32'h8765_4321);
        send_at(CMD_CONN, 32'd6000, 32'd0);
        send_at(CMD_PUB, 32'd6000, 32'd0);
        w     = '1;
        w.pad = '0;
        send_word(CMD_BEGIN, w);
        send_at(CMD_CLEAR, 32'd7000, 32'd0);
        send_at(CMD_QUERY, 32'd7000, 32'd0);
        send_at(CMD_SHELL, 32'hFFFF_C568, 32'd0);
        drain();

        // run the active count up and step back down
        ms_now = $urandom;
        for (int k = 0; k < FILL_BEGINS; k++) begin
            ms_now = ms_now + $urandom_range(0, 3);
            send_at(CMD_BEGIN, ms_now, 32'd0);
        end
        repeat (3) send_at(CMD_END, ms_now, 32'd0);
        send_at(CMD_CLEAR, ms_now, 32'd0);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: apply_config(32'(PAUSE_MS_RST), 32'(SHELL_MS_RST), 32'(WINDOW_MS_RST),
                                SLOW_MS_RST);
                1: apply_config(32'd0, 32'd0, 32'd0, 32'd0);
                2: apply_config(32'hFFFF, 32'hFFFF, 32'h1FFFF, 32'hFFFF_FFFF);
                default: apply_config($urandom_range(0, 65535), $urandom_range(0, 65535),
                                      $urandom_range(0, 131071), $urandom_range(0, 5000));
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 56; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 56; end
                default: begin send_idle_pct = 16; stall_pct = 16; end
            endcase
            ms_now = ph[0] ? 32'hFFFF_FFFF - $urandom_range(0, 100000) : $urandom;
            repeat (PHASE_WORDS) begin
                random_word(c, w);
                send_word(c, w);
                if ($urandom_range(0, 149) == 0) drain();
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (gate.pending() != 0) begin
            gate.error_count++;
            $display("%0t: status words missing, expected %0d actual 0",
                     $time, gate.pending());
        end
        if (gate.error_count == 0) begin
            $display("PASS transfer_pause_deadline_gate_top");
        end else begin
            $display("FAIL transfer_pause_deadline_gate_top");
        end
        $finish;
    end

endmodule
